/* design/obrq_pkg.sv */
// ----------------------------------------------------------------------------
// obrq_pkg: shared types and constants of the overwrite byte ring queue
// Holds the ring geometry, the operation codes and the structs that pass
// between the pointer unit and the top level.
// ----------------------------------------------------------------------------
package obrq_pkg;

  // Ring geometry
  localparam int DEPTH   = 1024;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int BYTE_W  = 8;
  localparam int OP_W    = 2;
  localparam int DEL_W   = 10;
  localparam int FILL_W  = 10;
  localparam int CMP_W   = (IDX_W > DEL_W) ? IDX_W : DEL_W;

  // Stream payload widths (fields packed from bit 0, padded to bytes)
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 24;

  typedef logic [OP_W-1:0]   op_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [BYTE_W-1:0] byte_t;

  // Operation codes
  localparam op_t OP_APPEND    = 2'd0;
  localparam op_t OP_OVERWRITE = 2'd1;
  localparam op_t OP_PEEK      = 2'd2;
  localparam op_t OP_DELETE    = 2'd3;

  // Memory request issued by the pointer unit for one transfer
  typedef struct packed {
    logic  wr_en;
    idx_t  wr_addr;
    byte_t wr_data;
    logic  rd_en;
    idx_t  rd_addr;
  } mem_req_t;

  // Status of the queue after one operation
  typedef struct packed {
    idx_t cnt;
    logic drop;
  } step_info_t;

endpackage

/* design/obrq_ram.sv */
// ----------------------------------------------------------------------------
// obrq_ram: generic single-clock RAM
// One write port and one read port; read data is registered and holds its
// value while no read is issued. A read of the address being written returns
// the old contents.
// ----------------------------------------------------------------------------
module obrq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* design/obrq_ctrl.sv */
// ----------------------------------------------------------------------------
// obrq_ctrl: head, tail and count registers of the ring
// Applies one operation per accepted transfer, issues the memory write for
// append and overwrite, and issues the read of the new head byte.
// ----------------------------------------------------------------------------
module obrq_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept,
  input  obrq_pkg::op_t        op,
  input  obrq_pkg::byte_t      data_byte,
  input  logic [obrq_pkg::DEL_W-1:0] delete_count,
  output obrq_pkg::mem_req_t   req,
  output obrq_pkg::step_info_t info
);
  import obrq_pkg::*;

  idx_t head_r, head_nxt;
  idx_t tail_r, tail_nxt;
  idx_t cnt_r, cnt_nxt;
  logic drop;

  logic [CMP_W-1:0] amount_ext;
  logic [CMP_W-1:0] cnt_ext;
  idx_t             step;
  logic [IDX_W:0]   pos;
  idx_t             tail_adv;
  idx_t             head_adv;

  // Pointer arithmetic
  always_comb begin
    amount_ext = CMP_W'(delete_count);
    cnt_ext    = CMP_W'(cnt_r);
    step       = (amount_ext > cnt_ext) ? cnt_r : IDX_W'(amount_ext);
    pos        = {1'b0, head_r} + {1'b0, step};
    if (pos >= (IDX_W+1)'(DEPTH)) begin
      pos = pos - (IDX_W+1)'(DEPTH);
    end
    tail_adv = (tail_r == IDX_W'(DEPTH-1)) ? '0 : tail_r + 1'b1;
    head_adv = (head_r == IDX_W'(DEPTH-1)) ? '0 : head_r + 1'b1;
  end

  // Next state per operation
  always_comb begin
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    cnt_nxt     = cnt_r;
    drop        = 1'b0;
    req.wr_en   = 1'b0;
    req.wr_addr = head_r;
    req.wr_data = data_byte;
    case (op)
      OP_APPEND: begin
        req.wr_en   = accept;
        req.wr_addr = tail_r;
        tail_nxt    = tail_adv;
        if (tail_adv == head_r) begin
          head_nxt = head_adv;
          drop     = 1'b1;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      OP_OVERWRITE: begin
        req.wr_en = accept;
      end
      OP_DELETE: begin
        if (cnt_r != '0) begin
          head_nxt = IDX_W'(pos);
          cnt_nxt  = cnt_r - step;
        end
      end
      default: begin
      end
    endcase
    req.rd_en   = accept;
    req.rd_addr = head_nxt;
    info.cnt    = cnt_nxt;
    info.drop   = drop;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else if (accept) begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

/* design/overwrite_byte_ring_queue.sv */
// ----------------------------------------------------------------------------
// overwrite_byte_ring_queue: byte ring queue that drops the oldest byte
// Each result passes through the read stage registers and then the output register.
// Throughput: one operation per cycle unless results stall; the pointer update
//   and one write plus one read of the byte RAM all happen in the accept cycle.
// Reset clears head, tail, count and the pipeline valids; the RAM is not
//   cleared, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module overwrite_byte_ring_queue (
  input  logic                            clk,
  input  logic                            rst_n,
  // Input channel
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [obrq_pkg::IN_DATA_W-1:0]  in_tdata,  // data_byte[7:0], delete_count[17:8]
  input  logic [obrq_pkg::OP_W-1:0]       in_tuser,  // op[1:0]
  // Result channel
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [obrq_pkg::OUT_DATA_W-1:0] out_tdata, // head_byte[7:0], fill_count[17:8]
  output logic                            out_tuser  // overwrote_oldest[0]
);
  import obrq_pkg::*;

  logic       accept;
  logic       s1_adv;
  mem_req_t   req;
  step_info_t info;
  byte_t      rd_data;

  // Read stage registers
  logic  s1_valid_r;
  logic  s1_fwd_r;
  byte_t s1_fwd_byte_r;
  idx_t  s1_cnt_r;
  logic  s1_drop_r;

  // Output registers
  logic  out_valid_r;
  byte_t out_byte_r;
  idx_t  out_cnt_r;
  logic  out_drop_r;

  byte_t head_byte;

  // Handshake: the read stage moves on whenever the output slot frees up
  assign s1_adv    = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || s1_adv;
  assign accept    = in_tvalid && in_tready;

  obrq_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .op           (in_tuser),
    .data_byte    (in_tdata[BYTE_W-1:0]),
    .delete_count (in_tdata[BYTE_W+DEL_W-1:BYTE_W]),
    .req          (req),
    .info         (info)
  );

  obrq_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (req.wr_en),
    .wr_addr (req.wr_addr),
    .wr_data (req.wr_data),
    .rd_en   (req.rd_en),
    .rd_addr (req.rd_addr),
    .rd_data (rd_data)
  );

  // Read stage: note when the head read hits the entry written this cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_fwd_r      <= req.wr_en && (req.wr_addr == req.rd_addr);
      s1_fwd_byte_r <= req.wr_data;
      s1_cnt_r      <= info.cnt;
      s1_drop_r     <= info.drop;
    end
  end

  // An empty queue reports a zero head byte
  always_comb begin
    if (s1_cnt_r == '0) begin
      head_byte = '0;
    end else if (s1_fwd_r) begin
      head_byte = s1_fwd_byte_r;
    end else begin
      head_byte = rd_data;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid_r) begin
      out_byte_r <= head_byte;
      out_cnt_r  <= s1_cnt_r;
      out_drop_r <= s1_drop_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_DATA_W-BYTE_W-FILL_W)'(0), FILL_W'(out_cnt_r), out_byte_r};
  assign out_tuser  = out_drop_r;

`ifndef SYNTH
  // A dropped byte only happens when the ring was holding DEPTH-1 bytes
  a_drop_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    accept && info.drop |-> u_ctrl.cnt_r == idx_t'(DEPTH-1))
    else $error("oldest byte dropped while ring not full");

  // An append that keeps the oldest byte grows the count by one
  a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_tuser == OP_APPEND) && !info.drop |=> s1_cnt_r == $past(u_ctrl.cnt_r) + 1'b1)
    else $error("append did not grow the count");

  // An empty result always carries a zero head byte
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_cnt_r == '0) |-> out_byte_r == '0)
    else $error("nonzero head byte reported for empty ring");

  // A stalled result blocks intake only while the read stage is full
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> s1_valid_r && out_valid_r && !out_tready)
    else $error("input stalled without a full pipeline");
`endif

endmodule

/* bench/overwrite_byte_ring_queue_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// overwrite_byte_ring_queue_test: self-checking bench for the byte ring queue
// Drives append, overwrite, peek and delete operations through the input
// stream and keeps its own copy of the ring to predict each result. Results
// are compared in order, field by field. Both stream sides idle at random,
// with some stretches at full rate.
// ----------------------------------------------------------------------------
module overwrite_byte_ring_queue_test;
  import obrq_pkg::*;

  // One queue status as reported on the result stream
  typedef struct {
    byte_t             head_byte;
    logic [FILL_W-1:0] fill_count;
    logic              overwrote_oldest;
  } queue_status_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;  // data_byte[7:0], delete_count[17:8]
  logic [OP_W-1:0]       in_tuser;  // op[1:0]
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata; // head_byte[7:0], fill_count[17:8]
  logic                  out_tuser; // overwrote_oldest[0]

  // Shadow copy of the ring
  byte_t ring_mem [DEPTH];
  int    head_pos;
  int    tail_pos;
  int    held_bytes;

  queue_status_t expected_status[$];
  int            error_count = 0;
  bit            steady = 1'b0;

  overwrite_byte_ring_queue dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // 50 MHz clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Apply one operation to the shadow ring and queue the status it leads to.
  function automatic void ring_apply(op_t op, byte_t value, logic [DEL_W-1:0] amount);
    queue_status_t st;
    int            step;
    st.overwrote_oldest = 1'b0;
    case (op)
      OP_APPEND: begin
        ring_mem[tail_pos] = value;
        tail_pos = (tail_pos + 1) % DEPTH;
        if (tail_pos == head_pos) begin
          // Full ring: the oldest byte falls out and the count holds.
          head_pos = (head_pos + 1) % DEPTH;
          st.overwrote_oldest = 1'b1;
        end else begin
          held_bytes++;
        end
      end
      OP_OVERWRITE: ring_mem[head_pos] = value;
      OP_DELETE: begin
        if (held_bytes != 0) begin
          step = (int'(amount) > held_bytes) ? held_bytes : int'(amount);
          head_pos = (head_pos + step) % DEPTH;
          held_bytes -= step;
        end
      end
      default: ;
    endcase
    st.head_byte  = (held_bytes != 0) ? ring_mem[head_pos] : '0;
    st.fill_count = held_bytes[FILL_W-1:0];
    expected_status.push_back(st);
  endfunction

  // Send one operation; the transfer is predicted at the edge that takes it.
  task automatic send_op(op_t op, byte_t value, logic [DEL_W-1:0] amount);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {{(IN_DATA_W - DEL_W - BYTE_W){1'b0}}, amount, value};
    do @(posedge clk); while (!in_tready);
    ring_apply(op, value, amount);
  endtask

  // Random operation with a given share of appends; the rest is split evenly.
  task automatic send_random(int append_pct, int max_delete);
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < append_pct)
      send_op(OP_APPEND, byte_t'($urandom), '0);
    else if (pick < append_pct + (100 - append_pct) / 3)
      send_op(OP_OVERWRITE, byte_t'($urandom), DEL_W'($urandom));
    else if (pick < append_pct + 2 * (100 - append_pct) / 3)
      send_op(OP_PEEK, byte_t'($urandom), DEL_W'($urandom));
    else
      send_op(OP_DELETE, byte_t'($urandom), DEL_W'($urandom_range(0, max_delete)));
  endtask

  // Drop valid and wait until every expected status has come back.
  task automatic drain;
    in_tvalid <= 1'b0;
    while (expected_status.size() != 0) @(posedge clk);
  endtask

  // Operations on an empty queue change nothing but the written head cell.
  task automatic test_empty_queue;
    send_op(OP_PEEK, 8'h00, '0);
    send_op(OP_DELETE, 8'h00, '0);
    send_op(OP_DELETE, 8'hFF, 10'd1023);
    send_op(OP_OVERWRITE, 8'hA5, 10'h155);
    send_op(OP_PEEK, 8'hFF, 10'h2AA);
  endtask

  // Each operation on a short queue, with field extremes and delete clamping.
  task automatic test_basic_ops;
    send_op(OP_APPEND, 8'h00, '0);
    send_op(OP_APPEND, 8'hFF, 10'd1023);
    send_op(OP_APPEND, 8'h5A, '0);
    send_op(OP_PEEK, 8'h00, '0);
    send_op(OP_OVERWRITE, 8'hFF, '0);
    send_op(OP_OVERWRITE, 8'h00, '0);
    send_op(OP_DELETE, 8'h00, 10'd0);
    send_op(OP_DELETE, 8'h00, 10'd1);
    send_op(OP_DELETE, 8'h00, 10'd1023);
    send_op(OP_APPEND, 8'h81, '0);
    send_op(OP_APPEND, 8'h7E, '0);
    send_op(OP_APPEND, 8'hC3, '0);
    send_op(OP_DELETE, 8'h00, 10'd2);
    send_op(OP_DELETE, 8'h00, 10'd1);
    send_op(OP_APPEND, 8'h3C, '0);
    send_op(OP_DELETE, 8'h00, 10'h2AA);
    send_op(OP_DELETE, 8'h00, 10'h155);
    drain();
  endtask

  // Fill past capacity so the tail wraps and appends start dropping bytes.
  task automatic test_fill_and_wrap;
    steady = 1'b1;
    for (int i = 0; i < 1030; i++) begin
      if (i == 300) steady = 1'b0;
      send_random(100, 0);
    end
    // Hold the sender until the queue has reported every status.
    drain();
  endtask

  // Mostly appends at full level, with small deletes and head overwrites.
  task automatic test_full_churn;
    for (int i = 0; i < 60; i++) send_random(60, 3);
  endtask

  // General mix that drains the queue often and deletes up to the limit.
  task automatic test_random_mix;
    for (int i = 0; i < 100; i++) begin
      if (i % 50 == 0) steady = ($urandom_range(0, 3) == 0);
      send_random(45, ($urandom_range(0, 3) == 0) ? 1023 : 12);
    end
    steady = 1'b0;
  endtask

  // Stimulus
  initial begin : stimulus
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= OP_PEEK;
    head_pos   = 0;
    tail_pos   = 0;
    held_bytes = 0;
    foreach (ring_mem[i]) ring_mem[i] = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_queue();
    test_basic_ops();
    test_fill_and_wrap();
    test_full_churn();
    test_random_mix();

    drain();
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Result side: random stalls, then compare each transfer with the oldest
  // expected status.
  initial begin : status_checker
    int            stall;
    queue_status_t want;
    out_tready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 13);
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      if (expected_status.size() == 0) begin
        $error("unexpected result transfer: tdata=%h tuser=%b", out_tdata, out_tuser);
        error_count++;
      end else begin
        want = expected_status.pop_front();
        if (out_tdata[BYTE_W-1:0] !== want.head_byte) begin
          $error("head_byte: expected %0d, got %0d", want.head_byte,
                 out_tdata[BYTE_W-1:0]);
          error_count++;
        end
        if (out_tdata[BYTE_W +: FILL_W] !== want.fill_count) begin
          $error("fill_count: expected %0d, got %0d", want.fill_count,
                 out_tdata[BYTE_W +: FILL_W]);
          error_count++;
        end
        if (out_tuser !== want.overwrote_oldest) begin
          $error("overwrote_oldest: expected %0d, got %0d", want.overwrote_oldest,
                 out_tuser);
          error_count++;
        end
      end
    end
  end

  // Watchdog
  initial begin : watchdog
    #50ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

/* filelist.f */
design/obrq_pkg.sv
design/obrq_ram.sv
design/obrq_ctrl.sv
design/overwrite_byte_ring_queue.sv
bench/overwrite_byte_ring_queue_test.sv
